@@ rtl/core/css_pkg.sv @@
// Shared types and constants for the contiguous subsequence search core.
package css_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

@@ rtl/core/css_front.sv @@
// Front end: takes input transactions, classifies them and queues them for the back end.
module css_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           kind,
  input  logic signed [31:0]   value,
  output css_pkg::queue_head_t head,
  input  logic                 pop
);
  import css_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       do_pop;

  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall;
  assign do_pop     = pop && (fill != 2'd0);

  assign head.valid = (fill != 2'd0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].kind  <= kind_t'(kind);
      slots[wr_ptr].value <= value;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !push) |=> (fill == $past(fill) - 2'd1))
    else $error("queue fill did not drop on pop");

endmodule

@@ rtl/core/css_back.sv @@
// Back end: executes queued transactions, runs the parallel window compare, holds the result.
module css_back #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  css_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 found,
  output logic [15:0]          position,
  output logic                 pattern_overflow
);
  import css_pkg::*;

  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int COUNT_W = $clog2(MAX_TEXT + 1);
  localparam int SW      = (COUNT_W > POS_W + 1) ? COUNT_W : POS_W + 1;

  logic [WORD_W-1:0]      pat_rev [MAX_PATTERN];
  logic [WORD_W-1:0]      window [MAX_PATTERN];
  logic [WORD_W-1:0]      window_next [MAX_PATTERN];
  logic [LEN_W-1:0]       len;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_inc;
  logic                   overflow;
  logic                   advance;
  logic                   exec;
  logic                   text_take;
  logic                   eligible;
  logic [SW-1:0]          start_wide;
  logic [MAX_PATTERN-1:0] eq;

  logic                   s1_valid;
  kind_t                  s1_kind;
  logic [MAX_PATTERN-1:0] s1_eq;
  logic                   s1_try;
  logic [POS_W-1:0]       s1_start;
  logic                   s1_overflow;

  logic                   match_seen;
  logic [POS_W-1:0]       first_start;

  assign advance = !result_valid || !result_stall;
  assign exec    = head.valid && advance;
  assign pop     = exec;

  assign text_take  = count < COUNT_W'(MAX_TEXT);
  assign count_inc  = count + 1'b1;
  assign start_wide = SW'(count_inc) - SW'(len);
  assign eligible   = text_take && (len != '0) && (SW'(count_inc) >= SW'(len))
                      && (start_wide[SW-1:POS_W] == '0);

  always_comb begin
    window_next[0] = head.entry.value;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_next[i] = window[i-1];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i] = (window_next[i] == pat_rev[i]) || !(LEN_W'(i) < len);
    end
  end

  // execute stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      count    <= '0;
      overflow <= 1'b0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= head.valid;
      if (exec) begin
        unique case (head.entry.kind)
          KIND_CLEAR: begin
            len      <= '0;
            count    <= '0;
            overflow <= 1'b0;
          end
          KIND_PATTERN: begin
            if (len < LEN_W'(MAX_PATTERN)) begin
              len <= len + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end
          KIND_TEXT: begin
            if (text_take) begin
              count <= count_inc;
            end
          end
          KIND_END: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // execute stage: payload
  always_ff @(posedge clk) begin
    if (exec) begin
      if (head.entry.kind == KIND_PATTERN && len < LEN_W'(MAX_PATTERN)) begin
        pat_rev[0] <= head.entry.value;
        for (int i = 1; i < MAX_PATTERN; i++) begin
          pat_rev[i] <= pat_rev[i-1];
        end
      end
      if (head.entry.kind == KIND_TEXT && text_take) begin
        window <= window_next;
      end
      s1_kind     <= head.entry.kind;
      s1_eq       <= eq;
      s1_try      <= (head.entry.kind == KIND_TEXT) && eligible;
      s1_start    <= start_wide[POS_W-1:0];
      s1_overflow <= overflow;
    end
  end

  // match stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen   <= 1'b0;
      first_start  <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid && (s1_kind == KIND_END);
      if (s1_valid) begin
        unique case (s1_kind)
          KIND_CLEAR: begin
            match_seen  <= 1'b0;
            first_start <= '0;
          end
          KIND_TEXT: begin
            if (s1_try && (&s1_eq) && !match_seen) begin
              match_seen  <= 1'b1;
              first_start <= s1_start;
            end
          end
          KIND_PATTERN, KIND_END: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_kind == KIND_END) begin
      found            <= match_seen;
      position         <= match_seen ? first_start : '0;
      pattern_overflow <= s1_overflow;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");
  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    (exec && head.entry.kind == KIND_CLEAR) |=> (len == '0 && count == '0 && !overflow))
    else $error("clear did not empty the state");
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (position == '0))
    else $error("position set without a match");

endmodule

@@ rtl/core/contiguous_subsequence_search_core.sv @@
// Top level of the contiguous subsequence search core.
// Finds the first start of a stored pattern (up to MAX_PATTERN signed words) as a contiguous
// run in a text stream of up to MAX_TEXT words. Every transaction, of any kind, is taken at
// one per cycle while neither stall is raised: the text window shifts and all MAX_PATTERN lane
// comparators evaluate in the execute stage, then a match stage folds the lanes and updates
// the first-match record. An end-of-text transaction passes through the queue, the execute
// stage and the match stage, whose result register holds its result; a two-entry queue between
// the front and back ends takes input while the back end stalls, until it is full. Clear, pattern
// and text transactions produce no result.
module contiguous_subsequence_search_core #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               found,
  output logic [15:0]        position,
  output logic               pattern_overflow
);
  import css_pkg::*;

  queue_head_t head;
  logic        pop;

  css_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .value      (value),
    .head       (head),
    .pop        (pop)
  );

  css_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .found            (found),
    .position         (position),
    .pattern_overflow (pattern_overflow)
  );

endmodule
